// File: sv/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list core
// Capacity, widths, request kinds, status codes, cell operations and states.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IN_IDX_W = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic              report;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } ctl_t;

endpackage

// File: sv/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell: one list position
// Holds one entry and takes its left neighbor, its right neighbor or a new
// value when the list shifts around it.
// ----------------------------------------------------------------------------
module ilir_cell
  import ilir_pkg::*;
(
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] load_data,
  output logic signed [DATA_W-1:0] data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:       data_nxt = data_r;
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      CELL_LOAD:       data_nxt = load_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: sv/ilir_ctrl.sv
// ----------------------------------------------------------------------------
// ilir_ctrl: request decode, occupancy and sequencing
// Checks a request against the occupancy, tells every cell what to do and
// steps the accept and report cycles.
// ----------------------------------------------------------------------------
module ilir_ctrl
  import ilir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [IN_IDX_W-1:0]  in_index,
  input  logic                 out_free,
  output cell_op_t             cell_op [CAPACITY],
  output ctl_t                 ctl
);

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  occ_r;
  logic [CNT_W-1:0]  occ_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic              accept;
  logic              ok;
  logic [CMP_W-1:0]  pos;
  logic [CMP_W-1:0]  occ_ext;

  assign pos     = CMP_W'(in_index);
  assign occ_ext = CMP_W'(occ_r);
  assign accept  = in_valid && in_ready;

  always_comb begin
    status_nxt = status_r;
    occ_nxt    = occ_r;
    ok         = 1'b0;
    if (accept) begin
      if (in_kind == KIND_INSERT) begin
        if (pos > occ_ext) begin
          status_nxt = ST_BOUNDS;
        end else if (occ_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          ok         = 1'b1;
          occ_nxt    = occ_r + CNT_W'(1);
        end
      end else begin
        if (pos >= occ_ext) begin
          status_nxt = ST_BOUNDS;
        end else begin
          status_nxt = ST_DONE;
          ok         = 1'b1;
          occ_nxt    = occ_r - CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
      if (ok) begin
        if (in_kind == KIND_INSERT) begin
          if (CMP_W'(i) > pos) begin
            cell_op[i] = CELL_FROM_LEFT;
          end else if (CMP_W'(i) == pos) begin
            cell_op[i] = CELL_LOAD;
          end
        end else if (CMP_W'(i) >= pos) begin
          cell_op[i] = CELL_FROM_RIGHT;
        end
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    ctl.report = 1'b0;
    ctl.status = status_r;
    ctl.count  = occ_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          ctl.report = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// File: sv/indexed_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core: ordered list with insert and remove
// A row of cells keeps the list in order and shifts it on acceptance; the
// result reports status, count, head, tail and an empty flag.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | request   | in_valid, in_ready, in_kind, in_index, in_value
//   out     | result    | out_valid, out_ready, out_status, out_count,
//           |           | out_head_value, out_tail_value, out_empty_res
//
// The cells shift at the accepting edge; the result register loads from the report
// state, so a new request is taken only once the last result has been loaded.
// The tail read through the occupancy-selected cell sets the report cycle.
// A result waiting in the output register does not block a new request; the
// report cycle waits only while the output register is still full.
// Reset clears the occupancy and the handshake state; cell contents are left.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core
  import ilir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [IN_IDX_W-1:0]      in_index,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count,
  output logic signed [DATA_W-1:0] out_head_value,
  output logic signed [DATA_W-1:0] out_tail_value,
  output logic                     out_empty_res
);

  cell_op_t                 cell_op [CAPACITY];
  ctl_t                     ctl;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic                     out_free;
  logic [CNT_W-1:0]         last;

  logic                     out_valid_r;
  logic [1:0]               status_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [DATA_W-1:0] head_r;
  logic signed [DATA_W-1:0] tail_r;
  logic                     empty_r;

  assign out_free = !out_valid_r || out_ready;

  ilir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_index (in_index),
    .out_free (out_free),
    .cell_op  (cell_op),
    .ctl      (ctl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[g+1];
    end
    ilir_cell u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .left_data  (left_d),
      .right_data (right_d),
      .load_data  (in_value),
      .data       (entry[g])
    );
  end

  assign last = ctl.count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      status_r <= ctl.status;
      count_r  <= ctl.count;
      empty_r  <= (ctl.count == '0);
      if (ctl.count == '0) begin
        head_r <= '0;
        tail_r <= '0;
      end else begin
        head_r <= entry[0];
        tail_r <= entry[last[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = count_r;
  assign out_head_value = head_r;
  assign out_tail_value = tail_r;
  assign out_empty_res  = empty_r;

endmodule

// File: sv/ilir_checker.sv
// ----------------------------------------------------------------------------
// ilir_checker: port-level checks for the indexed list core
// Watches the result channel for consistent results and a held result.
// ----------------------------------------------------------------------------
module ilir_checker
  import ilir_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_status,
  input logic [CNT_W-1:0]         out_count,
  input logic signed [DATA_W-1:0] out_head_value,
  input logic signed [DATA_W-1:0] out_tail_value,
  input logic                     out_empty_res
);

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("Empty flag does not match the count.");

  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_head_value == '0 && out_tail_value == '0))
    else $error("An empty list reports a nonzero head or tail.");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == CNT_W'(CAPACITY)))
    else $error("A full status came with a list that is not full.");

  a_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == CNT_W'(1)) |-> (out_head_value == out_tail_value))
    else $error("A one-entry list reports different head and tail.");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("A stalled result was dropped or changed.");

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_head_value (out_head_value),
  .out_tail_value (out_tail_value),
  .out_empty_res  (out_empty_res)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request and result check for the indexed list core
// A short table of directed requests walks the list through empty, single
// entry, full and rejected cases. Random requests follow, steered so that the
// list swings between empty and full. Each result is compared with a software
// list copy kept in step with each accepted request, or a typed row's want.
// ----------------------------------------------------------------------------
module testbench;
  import ilir_pkg::*;

  localparam int RAND_ITEMS   = 1875;
  localparam int HOLD_CYCLES  = 150;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SHOWN_ERRORS = 40;

  typedef struct packed {
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] tail;
    logic                     empty;
  } list_result_t;

  typedef struct {
    kind_t                    kind;
    logic [IN_IDX_W-1:0]      index;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    list_result_t             want;
  } plan_row_t;

  localparam list_result_t NO_WANT = '0;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_kind = 1'b0;
  logic [IN_IDX_W-1:0]      in_index = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_count;
  logic signed [DATA_W-1:0] out_head_value;
  logic signed [DATA_W-1:0] out_tail_value;
  logic                     out_empty_res;

  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len = 0;
  list_result_t             outcome_q [$];
  plan_row_t                plan [$];
  int                       errors = 0;
  int                       cycles = 0;
  bit                       burst = 1'b0;
  bit                       calm = 1'b0;
  int                       hold_seq = 0;
  int                       hold_seen = 0;
  int                       hold_left = 0;
  int                       stall_left = 0;

  indexed_list_insert_remove_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_head_value (out_head_value),
    .out_tail_value (out_tail_value),
    .out_empty_res  (out_empty_res)
  );

  always #1 clk = ~clk;

  function automatic list_result_t apply_request(kind_t k, logic [IN_IDX_W-1:0] idx,
                                                 logic signed [DATA_W-1:0] v);
    list_result_t r;
    int           i;
    r.status = ST_DONE;
    if (k == KIND_INSERT) begin
      if (int'(idx) > list_len) begin
        r.status = ST_BOUNDS;
      end else if (list_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (i = list_len; i > int'(idx); i--) list_mem[i] = list_mem[i-1];
        list_mem[int'(idx)] = v;
        list_len++;
      end
    end else begin
      if (int'(idx) >= list_len) begin
        r.status = ST_BOUNDS;
      end else begin
        for (i = int'(idx); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    r.count = CNT_W'(list_len);
    r.head  = (list_len > 0) ? list_mem[0] : '0;
    r.tail  = (list_len > 0) ? list_mem[list_len-1] : '0;
    r.empty = (list_len == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(kind_t k, logic [IN_IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] v, bit typed, list_result_t want);
    list_result_t predicted;
    int           gap;
    in_valid <= 1'b1;
    in_kind  <= k;
    in_index <= idx;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(k, idx, v);
    outcome_q.push_back(typed ? want : predicted);
    gap = (burst || calm) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cmp_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        w = outcome_q.pop_front();
        cmp_field("status", DATA_W'(w.status), DATA_W'(out_status));
        cmp_field("count", DATA_W'(w.count), DATA_W'(out_count));
        cmp_field("head_value", w.head, out_head_value);
        cmp_field("tail_value", w.tail, out_tail_value);
        cmp_field("empty_res", DATA_W'(w.empty), DATA_W'(out_empty_res));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n || hold_left > 0) begin
      out_ready <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    kind_t                    k;
    logic [IN_IDX_W-1:0]      idx;
    logic signed [DATA_W-1:0] v;
    int                       bias;
    int                       roll;
    int                       n;

    // Empty list, single entry at both extremes, a small list, then fill to
    // capacity and reject further inserts.
    plan.push_back('{KIND_REMOVE, 5'd0, 32'sd0, 1'b1,
                     '{ST_BOUNDS, 5'd0, 32'sd0, 32'sd0, 1'b1}});
    plan.push_back('{KIND_INSERT, 5'd1, 32'sd5, 1'b1,
                     '{ST_BOUNDS, 5'd0, 32'sd0, 32'sd0, 1'b1}});
    plan.push_back('{KIND_INSERT, 5'd0, VAL_MAX, 1'b1,
                     '{ST_DONE, 5'd1, VAL_MAX, VAL_MAX, 1'b0}});
    plan.push_back('{KIND_REMOVE, 5'd0, 32'sd0, 1'b1,
                     '{ST_DONE, 5'd0, 32'sd0, 32'sd0, 1'b1}});
    plan.push_back('{KIND_INSERT, 5'd0, VAL_MIN, 1'b1,
                     '{ST_DONE, 5'd1, VAL_MIN, VAL_MIN, 1'b0}});
    plan.push_back('{KIND_INSERT, 5'd1, -32'sd1, 1'b0, NO_WANT});
    plan.push_back('{KIND_INSERT, 5'd0, 32'sd0, 1'b0, NO_WANT});
    plan.push_back('{KIND_INSERT, 5'd31, 32'sd9, 1'b1,
                     '{ST_BOUNDS, 5'd3, 32'sd0, -32'sd1, 1'b0}});
    for (n = 0; n < 13; n++)
      plan.push_back('{KIND_INSERT, IN_IDX_W'((n * 7) % (n + 4)), DATA_W'($urandom),
                       1'b0, NO_WANT});
    plan.push_back('{KIND_INSERT, 5'd0, 32'sd1, 1'b0, NO_WANT});
    plan.push_back('{KIND_INSERT, 5'd17, 32'sd2, 1'b0, NO_WANT});
    plan.push_back('{KIND_REMOVE, 5'd15, 32'sd0, 1'b0, NO_WANT});
    plan.push_back('{KIND_REMOVE, 5'd5, 32'sd0, 1'b0, NO_WANT});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r])
      send_request(plan[r].kind, plan[r].index, plan[r].value, plan[r].typed, plan[r].want);

    bias = 50;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == 500) begin
        hold_seq++;
        burst = 1'b1;
      end
      if (n == 620) burst = 1'b0;
      if (n == 1000) begin
        in_valid <= 1'b0;
        wait (outcome_q.size() == 0);
        @(posedge clk);
      end
      calm = (n >= 1300 && n < 1400);

      // Swing the list between empty and full so both ends see traffic.
      if (list_len == CAPACITY) bias = 25;
      else if (list_len == 0) bias = 80;
      else if (n % 150 == 0) bias = $urandom_range(30, 70);

      k = ($urandom_range(0, 99) < bias) ? KIND_INSERT : KIND_REMOVE;
      roll = $urandom_range(0, 99);
      if (roll < 15 || (k == KIND_REMOVE && list_len == 0))
        idx = IN_IDX_W'($urandom_range(0, 31));
      else if (k == KIND_INSERT)
        idx = (roll < 35) ? '0 : (roll < 55) ? IN_IDX_W'(list_len)
                                             : IN_IDX_W'($urandom_range(0, list_len));
      else
        idx = (roll < 35) ? '0 : (roll < 55) ? IN_IDX_W'(list_len - 1)
                                             : IN_IDX_W'($urandom_range(0, list_len - 1));

      roll = $urandom_range(0, 99);
      if (roll < 3) v = VAL_MIN;
      else if (roll < 6) v = VAL_MAX;
      else if (roll < 8) v = '0;
      else if (roll < 10) v = -32'sd1;
      else v = DATA_W'($urandom);

      send_request(k, idx, v, 1'b0, NO_WANT);
    end

    in_valid <= 1'b0;
    wait (outcome_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: indexed_list_insert_remove_core.f
sv/ilir_pkg.sv
sv/ilir_cell.sv
sv/ilir_ctrl.sv
sv/indexed_list_insert_remove_core.sv
sv/ilir_checker.sv
tb/testbench.sv
